### src/ewq_pkg.sv
// shared types and constants of the event-matched wait queue
package ewq_pkg;

    localparam logic [7:0] EVENT_NONE  = 8'd0;
    localparam logic [7:0] LOCKER_NONE = 8'd0;
    localparam logic [4:0] CAP_RESET   = 5'd16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_TAKE   = 2'd1,
        OP_SIGNAL = 2'd2,
        OP_FLUSH  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_PLAIN   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_SHUT    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [7:0] thread;
        logic [7:0] locker;
        logic [7:0] event_code;
    } t_waiter;

    typedef struct packed {
        logic load;
        logic take;
        logic shift;
    } t_cell_ctl;

endpackage

### src/event_matched_wait_queue.sv
// event-matched wait queue: a row of waiter slots with oldest-first matching
//
//  channel   | ports                                          | direction
//  ----------+------------------------------------------------+----------
//  command   | i_start, o_busy, i_op, i_thread_id,            | in
//            | i_locker_id, i_event_req                       |
//  result    | o_done, o_ok, o_action, o_found_thread,        | out
//            | o_found_locker, o_found_event, o_last          |
//  config    | i_cfg_we, i_cfg_data (capacity)                | in
//
// add, take and signal latch the command in ST_IDLE and do the match across the
// slot row in ST_EXEC; the result beat follows in the cycle after the match.
// flush gives one beat per waiter shifted out of slot 0, or a single beat when empty.
// reset empties the queue and sets capacity to 16; no clearing pass is needed.
// o_busy is high while a command is in work; results cannot be stalled.
module event_matched_wait_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_op,
    input  logic [7:0] i_thread_id,
    input  logic [7:0] i_locker_id,
    input  logic [7:0] i_event_req,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    output logic       o_done,
    output logic       o_ok,
    output logic [1:0] o_action,
    output logic [7:0] o_found_thread,
    output logic [7:0] o_found_locker,
    output logic [7:0] o_found_event,
    output logic       o_last
);
    import ewq_pkg::*;

    localparam int         CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int         IdW    = (ID_BITS < 8) ? ID_BITS : 8;
    localparam logic [7:0] IdMask = 8'((32'd1 << IdW) - 32'd1);
    localparam logic [7:0] DepthL = 8'(QUEUE_DEPTH);

    t_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [4:0] r_cap;
    t_op       r_op;
    t_waiter   r_req;
    logic      r_done, n_done;
    logic      r_ok, n_ok;
    t_action   r_action, n_action;
    t_waiter   r_found, n_found;
    logic      r_last, n_last;

    t_cell_ctl ctl;
    t_waiter   req;
    t_waiter   new_w;
    logic      full;
    logic [7:0] cap_lim;

    t_waiter   cell_data  [QUEUE_DEPTH];
    logic      cell_prior [QUEUE_DEPTH+1];
    t_waiter   cell_found [QUEUE_DEPTH+1];

    assign cell_prior[0] = 1'b0;
    assign cell_found[0] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        t_cell_ctl c;
        t_waiter   nxt;
        assign c.load  = ctl.load && (r_count == CW'(i));
        assign c.take  = ctl.take;
        assign c.shift = ctl.shift;
        if (i < QUEUE_DEPTH - 1) begin : g_mid
            assign nxt = cell_data[i+1];
        end else begin : g_end
            assign nxt = '0;
        end
        ewq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (c),
            .i_occupied (r_count > CW'(i)),
            .i_req      (req),
            .i_new      (new_w),
            .i_next     (nxt),
            .i_prior    (cell_prior[i]),
            .i_found    (cell_found[i]),
            .o_data     (cell_data[i]),
            .o_prior    (cell_prior[i+1]),
            .o_found    (cell_found[i+1])
        );
    end

    always_comb begin
        cap_lim = ({3'b000, r_cap} > DepthL) ? DepthL : {3'b000, r_cap};
        full    = 8'(r_count) >= cap_lim;
        new_w   = r_req;
        req.thread     = '0;
        req.locker     = (r_op == OP_SIGNAL) ? LOCKER_NONE : r_req.locker;
        req.event_code = r_req.event_code;
    end

    // next state, counters and result beat
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_done   = 1'b0;
        n_ok     = 1'b0;
        n_action = ACT_PLAIN;
        n_found  = '0;
        n_last   = 1'b0;
        ctl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (t_op'(i_op) == OP_FLUSH) ? ST_FLUSH : ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                n_last  = 1'b1;
                case (r_op)
                    OP_ADD: begin
                        if (r_req.event_code != EVENT_NONE && r_req.locker != LOCKER_NONE
                                && !full) begin
                            ctl.load = 1'b1;
                            n_count  = r_count + 1'b1;
                            n_ok     = 1'b1;
                        end
                    end
                    OP_TAKE, OP_SIGNAL: begin
                        if (!(req.event_code == EVENT_NONE && req.locker == LOCKER_NONE)) begin
                            ctl.take = 1'b1;
                            if (cell_prior[QUEUE_DEPTH]) begin
                                n_ok     = 1'b1;
                                n_found  = cell_found[QUEUE_DEPTH];
                                n_count  = r_count - 1'b1;
                                n_action = (r_op == OP_SIGNAL) ? ACT_RELEASE : ACT_PLAIN;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_FLUSH: begin
                n_done = 1'b1;
                n_ok   = 1'b1;
                if (r_count == '0) begin
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    ctl.shift = 1'b1;
                    n_action  = ACT_SHUT;
                    n_found   = cell_data[0];
                    n_last    = (r_count == CW'(1));
                    n_count   = r_count - 1'b1;
                    if (r_count == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_state == ST_IDLE) begin
            r_op             <= t_op'(i_op);
            r_req.thread     <= i_thread_id & IdMask;
            r_req.locker     <= i_locker_id & IdMask;
            r_req.event_code <= i_event_req;
        end
        r_ok     <= n_ok;
        r_action <= n_action;
        r_found  <= n_found;
        r_last   <= n_last;
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_action       = r_action;
    assign o_found_thread = r_found.thread;
    assign o_found_locker = r_found.locker;
    assign o_found_event  = r_found.event_code;
    assign o_last         = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= QUEUE_DEPTH)
        else $error("waiter count beyond depth");

    a_beat_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_state != ST_IDLE))
        else $error("result beat without a command in work");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_action == ACT_SHUT && r_last) |-> (r_count == '0))
        else $error("queue not empty after final flush beat");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_ok) |-> (r_found == '0 && r_action == ACT_PLAIN))
        else $error("failed beat carries waiter data");

endmodule

### src/ewq_cell.sv
// one queue slot: holds a waiter, matches a take request and shifts towards the head
module ewq_cell (
    input  logic              i_clk,
    input  ewq_pkg::t_cell_ctl i_ctl,
    input  logic              i_occupied,
    input  ewq_pkg::t_waiter  i_req,
    input  ewq_pkg::t_waiter  i_new,
    input  ewq_pkg::t_waiter  i_next,
    input  logic              i_prior,
    input  ewq_pkg::t_waiter  i_found,
    output ewq_pkg::t_waiter  o_data,
    output logic              o_prior,
    output ewq_pkg::t_waiter  o_found
);
    import ewq_pkg::*;

    t_waiter r_data;
    logic    match;

    always_comb begin
        match = i_ctl.take && i_occupied
             && (i_req.event_code == EVENT_NONE || r_data.event_code == i_req.event_code)
             && (i_req.locker == LOCKER_NONE || r_data.locker == i_req.locker);
        o_prior = i_prior | match;
        o_found = (match && !i_prior) ? r_data : i_found;
        o_data  = r_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_new;
        end else if (i_ctl.shift || (i_ctl.take && (i_prior || match))) begin
            r_data <= i_next;
        end
    end

endmodule

### tb/event_matched_wait_queue_test.sv
// testbench for the event-matched wait queue: directed and random commands checked against a predictor
module event_matched_wait_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ewq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic       ok;
        t_action    action;
        logic [7:0] thread;
        logic [7:0] locker;
        logic [7:0] event_code;
        logic       last;
    } t_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    logic [1:0] i_op;
    logic [7:0] i_thread_id;
    logic [7:0] i_locker_id;
    logic [7:0] i_event_req;
    logic       i_cfg_we;
    logic [4:0] i_cfg_data;
    logic       o_done;
    logic       o_ok;
    logic [1:0] o_action;
    logic [7:0] o_found_thread;
    logic [7:0] o_found_locker;
    logic [7:0] o_found_event;
    logic       o_last;

    t_waiter waiter_row[$];
    t_beat   pending_beats[$];
    t_beat   head_beat;
    int      capacity_reg;
    int      errors;
    int      cycle_count;
    bit      gaps_on;

    event_matched_wait_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_BITS    (8)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_op          (i_op),
        .i_thread_id   (i_thread_id),
        .i_locker_id   (i_locker_id),
        .i_event_req   (i_event_req),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_ok          (o_ok),
        .o_action      (o_action),
        .o_found_thread(o_found_thread),
        .o_found_locker(o_found_locker),
        .o_found_event (o_found_event),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic predict_op(input t_op op, input logic [7:0] thread,
                              input logic [7:0] locker, input logic [7:0] ev);
        t_beat      b;
        t_waiter    w;
        int         hit;
        int         lim;
        logic [7:0] want_locker;
        b = '{ok: 1'b0, action: ACT_PLAIN, thread: 8'd0, locker: 8'd0,
               event_code: 8'd0, last: 1'b1};
        case (op)
            OP_ADD: begin
                lim = (capacity_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : capacity_reg;
                if (ev != EVENT_NONE && locker != LOCKER_NONE && waiter_row.size() < lim) begin
                    w.thread     = thread;
                    w.locker     = locker;
                    w.event_code = ev;
                    waiter_row.push_back(w);
                    b.ok = 1'b1;
                end
                pending_beats.push_back(b);
            end
            OP_TAKE, OP_SIGNAL: begin
                want_locker = (op == OP_SIGNAL) ? LOCKER_NONE : locker;
                hit = -1;
                if (ev != EVENT_NONE || want_locker != LOCKER_NONE) begin
                    for (int i = 0; i < waiter_row.size() && hit < 0; i++) begin
                        if ((ev == EVENT_NONE || waiter_row[i].event_code == ev) &&
                            (want_locker == LOCKER_NONE || waiter_row[i].locker == want_locker))
                            hit = i;
                    end
                end
                if (hit >= 0) begin
                    b.ok         = 1'b1;
                    b.action     = (op == OP_SIGNAL) ? ACT_RELEASE : ACT_PLAIN;
                    b.thread     = waiter_row[hit].thread;
                    b.locker     = waiter_row[hit].locker;
                    b.event_code = waiter_row[hit].event_code;
                    waiter_row.delete(hit);
                end
                pending_beats.push_back(b);
            end
            default: begin
                b.ok = 1'b1;
                if (waiter_row.size() == 0) begin
                    pending_beats.push_back(b);
                end else begin
                    foreach (waiter_row[i]) begin
                        b.action     = ACT_SHUT;
                        b.thread     = waiter_row[i].thread;
                        b.locker     = waiter_row[i].locker;
                        b.event_code = waiter_row[i].event_code;
                        b.last       = (i == waiter_row.size() - 1);
                        pending_beats.push_back(b);
                    end
                    waiter_row.delete();
                end
            end
        endcase
    endtask

    task automatic send_cmd(input t_op op, input logic [7:0] thread,
                            input logic [7:0] locker, input logic [7:0] ev);
        int gap;
        if (gaps_on && $urandom_range(99) < 11) begin
            gap = $urandom_range(1, 4);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_op        <= op;
        i_thread_id <= thread;
        i_locker_id <= locker;
        i_event_req <= ev;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_op(op, thread, locker, ev);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        i_start <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        capacity_reg = cap;
        waiter_row.delete();
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                head_beat = pending_beats.pop_front();
                check_field("ok", head_beat.ok, o_ok);
                check_field("action", head_beat.action, o_action);
                check_field("found_thread", head_beat.thread, o_found_thread);
                check_field("found_locker", head_beat.locker, o_found_locker);
                check_field("found_event", head_beat.event_code, o_found_event);
                check_field("last", head_beat.last, o_last);
            end
        end
    end

    function automatic logic [7:0] random_id();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 8'd0;
        if (r < 75)
            return 8'($urandom_range(1, 6));
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic check_rejects_on_empty_queue();
        send_cmd(OP_FLUSH, 8'd0, 8'd0, 8'd0);
        send_cmd(OP_ADD, 8'd1, 8'd3, EVENT_NONE);
        send_cmd(OP_ADD, 8'd1, LOCKER_NONE, 8'd3);
        send_cmd(OP_TAKE, 8'd0, LOCKER_NONE, EVENT_NONE);
        send_cmd(OP_SIGNAL, 8'd0, 8'd4, EVENT_NONE);
    endtask

    task automatic check_oldest_first_matching();
        send_cmd(OP_ADD, 8'hff, 8'hff, 8'hff);
        send_cmd(OP_ADD, 8'h00, 8'h01, 8'h01);
        send_cmd(OP_ADD, 8'h5a, 8'h02, 8'h80);
        send_cmd(OP_ADD, 8'ha5, 8'h01, 8'h80);
        send_cmd(OP_TAKE, 8'h00, 8'h07, 8'h09);
        send_cmd(OP_TAKE, 8'h00, LOCKER_NONE, 8'h80);
        send_cmd(OP_TAKE, 8'h00, 8'h01, EVENT_NONE);
        send_cmd(OP_SIGNAL, 8'h00, 8'h00, 8'hff);
        send_cmd(OP_FLUSH, 8'hff, 8'hff, 8'hff);
    endtask

    task automatic check_capacity_limits();
        write_capacity(5'd0);
        send_cmd(OP_ADD, 8'd9, 8'd1, 8'd1);
        write_capacity(5'd1);
        send_cmd(OP_ADD, 8'd9, 8'd1, 8'd1);
        send_cmd(OP_ADD, 8'd8, 8'd2, 8'd2);
        send_cmd(OP_FLUSH, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic run_random_traffic(input int n_items, input logic [4:0] cap,
                                      input int add_pct);
        int         kind;
        t_waiter    w;
        logic [7:0] loc;
        logic [7:0] ev;
        write_capacity(cap);
        repeat (n_items) begin
            if (waiter_row.size() != 0) begin
                w = waiter_row[$urandom_range(waiter_row.size() - 1)];
            end else begin
                w.thread     = 8'($urandom_range(255));
                w.locker     = random_id();
                w.event_code = random_id();
            end
            kind = $urandom_range(99);
            if ($urandom_range(99) < add_pct) begin
                send_cmd(OP_ADD, 8'($urandom_range(255)), random_id(), random_id());
            end else if (kind < 45) begin
                if ($urandom_range(99) < 70) begin
                    loc = w.locker;
                    ev  = w.event_code;
                    case ($urandom_range(2))
                        0: loc = LOCKER_NONE;
                        1: ev  = EVENT_NONE;
                        default: ;
                    endcase
                end else begin
                    loc = random_id();
                    ev  = random_id();
                end
                send_cmd(OP_TAKE, 8'($urandom_range(255)), loc, ev);
            end else if (kind < 82) begin
                ev = ($urandom_range(99) < 70) ? w.event_code : random_id();
                send_cmd(OP_SIGNAL, 8'($urandom_range(255)), 8'($urandom_range(255)), ev);
            end else begin
                send_cmd(OP_FLUSH, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_op        <= OP_ADD;
        i_thread_id <= 8'd0;
        i_locker_id <= 8'd0;
        i_event_req <= 8'd0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= 5'd0;
        errors       = 0;
        gaps_on      = 1'b1;
        capacity_reg = CAP_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_rejects_on_empty_queue();
        check_oldest_first_matching();
        check_capacity_limits();
        run_random_traffic(70, 5'd31, 70);
        run_random_traffic(50, CAP_RESET, 50);
        run_random_traffic(30, 5'd1, 45);
        run_random_traffic(60, 5'($urandom_range(2, 15)), 55);
        gaps_on = 1'b0;
        run_random_traffic(60, 5'd8, 55);
        gaps_on = 1'b1;
        run_random_traffic(10, 5'd0, 60);
        run_random_traffic(30, 5'd31, 60);

        i_start <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
